/* src/frustum_box_cull_core_macros.svh */
// ----------------------------------------------------------------------------
// frustum_box_cull_core assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_CORE_MACROS_SVH
`define FRUSTUM_BOX_CULL_CORE_MACROS_SVH

// same-cycle implication
`define FBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fbc_pkg.sv */
// ----------------------------------------------------------------------------
// fbc_pkg
// Fixed constants and item codes of the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    // port field width of every coordinate and matrix entry
    localparam int FIELD_W      = 32;
    // fraction bits of the Q16.16 numbers
    localparam int FRAC_BITS    = 16;
    localparam int PLANE_COUNT  = 6;
    localparam int COLUMN_COUNT = 4;
    localparam int AXIS_COUNT   = 3;
    localparam int CNT_W        = $clog2(PLANE_COUNT);
    localparam int COL_W        = $clog2(COLUMN_COUNT);

    typedef logic t_kind;

    // item kinds
    localparam t_kind KIND_LOAD = 1'b0;
    localparam t_kind KIND_TEST = 1'b1;

endpackage

/* src/frustum_box_cull_core.sv */
// ----------------------------------------------------------------------------
// frustum_box_cull_core
// Culls axis-aligned boxes against the six clip planes of a projection-view
// matrix, one plane per cycle through a shared three-multiplier dot unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall    | kind, column, entries, box
//  out     | output    | o_out_valid / i_out_stall  | visible
//
//  A load word writes one column of all six planes. A test word runs through
//  accept, one plane at a time on the dot unit for all six planes, a drain
//  step to sum the last plane and a done step to hand the result to the output
//  register. The input stalls while a test runs; a stalled output holds the
//  block in its last step until the result register frees up.
//  Synchronous active-low reset clears control and all plane coefficients.
// ----------------------------------------------------------------------------
`include "frustum_box_cull_core_macros.svh"

module frustum_box_cull_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [1:0]                          i_column,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_entry_0,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_entry_1,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_entry_2,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_entry_3,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_min_x,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_min_y,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_min_z,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_max_x,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_max_y,
    input  logic signed [fbc_pkg::FIELD_W-1:0]  i_box_max_z,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_visible
);

    // coefficient, product and sum widths
    localparam int CW = COORD_BITS + 1;
    localparam int PW = CW + COORD_BITS;
    localparam int SW = PW + 2;

    localparam logic [fbc_pkg::CNT_W-1:0] LAST_PLANE = fbc_pkg::CNT_W'(fbc_pkg::PLANE_COUNT - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [fbc_pkg::CNT_W-1:0]   r_cnt;
    logic [fbc_pkg::CNT_W-1:0]   n_cnt;

    logic signed [CW-1:0] r_coef [fbc_pkg::PLANE_COUNT][fbc_pkg::COLUMN_COUNT];
    logic signed [COORD_BITS-1:0] r_lo [fbc_pkg::AXIS_COUNT];
    logic signed [COORD_BITS-1:0] r_hi [fbc_pkg::AXIS_COUNT];

    // dot unit stage registers
    logic                  r_a_vld;
    logic                  r_a_skip;
    logic signed [PW-1:0]  r_a_prod [fbc_pkg::AXIS_COUNT];
    logic signed [CW-1:0]  r_a_ofs;

    logic                  r_vis;
    logic                  r_out_vld;
    logic                  r_out_vis;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic signed [COORD_BITS-1:0]  w_ent [fbc_pkg::COLUMN_COUNT];
    logic signed [COORD_BITS-1:0]  w_vert [fbc_pkg::AXIS_COUNT];
    logic signed [PW-1:0]          w_prod [fbc_pkg::AXIS_COUNT];
    logic                          w_zero;
    logic signed [SW-1:0]          w_sum;
    logic                          w_behind;

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_visible   = r_out_vis;

    // low COORD_BITS of each entry, sign taken from the top kept bit
    assign w_ent[0] = i_entry_0[COORD_BITS-1:0];
    assign w_ent[1] = i_entry_1[COORD_BITS-1:0];
    assign w_ent[2] = i_entry_2[COORD_BITS-1:0];
    assign w_ent[3] = i_entry_3[COORD_BITS-1:0];

    // plane store: a load writes one column of all six planes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin
                for (int c = 0; c < fbc_pkg::COLUMN_COUNT; c++) begin
                    r_coef[p][c] <= '0;
                end
            end
        end else if (w_in_acc && i_kind == fbc_pkg::KIND_LOAD) begin
            for (int r = 0; r < fbc_pkg::AXIS_COUNT; r++) begin
                r_coef[2*r][i_column]   <= CW'(w_ent[3]) + CW'(w_ent[r]);
                r_coef[2*r+1][i_column] <= CW'(w_ent[3]) - CW'(w_ent[r]);
            end
        end
    end

    // box capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_kind == fbc_pkg::KIND_TEST) begin
            r_lo[0] <= i_box_min_x[COORD_BITS-1:0];
            r_lo[1] <= i_box_min_y[COORD_BITS-1:0];
            r_lo[2] <= i_box_min_z[COORD_BITS-1:0];
            r_hi[0] <= i_box_max_x[COORD_BITS-1:0];
            r_hi[1] <= i_box_max_y[COORD_BITS-1:0];
            r_hi[2] <= i_box_max_z[COORD_BITS-1:0];
        end
    end

    // dot unit, first stage: positive vertex and three products
    always_comb begin
        for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
            w_vert[i] = r_coef[r_cnt][i][CW-1] ? r_lo[i] : r_hi[i];
            w_prod[i] = r_coef[r_cnt][i] * w_vert[i];
        end
        w_zero = (r_coef[r_cnt][0] == '0) && (r_coef[r_cnt][1] == '0)
              && (r_coef[r_cnt][2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= (r_state == ST_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
            r_a_prod[i] <= w_prod[i];
        end
        r_a_ofs  <= r_coef[r_cnt][3];
        r_a_skip <= w_zero;
    end

    // dot unit, second stage: exact distance, offset scaled by 2^16
    assign w_sum = SW'(r_a_prod[0]) + SW'(r_a_prod[1]) + SW'(r_a_prod[2])
                 + (SW'(r_a_ofs) <<< fbc_pkg::FRAC_BITS);
    assign w_behind = w_sum[SW-1];

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_kind == fbc_pkg::KIND_TEST) begin
            r_vis <= 1'b1;
        end else if (r_a_vld && !r_a_skip && w_behind) begin
            r_vis <= 1'b0;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_kind == fbc_pkg::KIND_TEST) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST_PLANE) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_vis <= r_vis;
        end
    end

    // checks
    `FBC_ASSERT_NXT(a_test_starts, w_in_acc && i_kind == fbc_pkg::KIND_TEST, r_state == ST_RUN && r_cnt == '0, "test word did not start plane sweep")
    `FBC_ASSERT_NXT(a_load_stays_idle, w_in_acc && i_kind == fbc_pkg::KIND_LOAD, r_state == ST_IDLE, "load word left idle")
    `FBC_ASSERT_IMP(a_cnt_range, r_state == ST_RUN, r_cnt <= LAST_PLANE, "plane counter out of range")
    `FBC_ASSERT_IMP(a_stage_from_run, r_a_vld, $past(r_state) == ST_RUN, "dot stage valid outside sweep")
    `FBC_ASSERT_IMP(a_result_from_done, $rose(o_out_valid), $past(r_state) == ST_DONE, "result raised outside final step")

endmodule

/* bench/tb_frustum_box_cull_core.sv */
// ----------------------------------------------------------------------------
// tb_frustum_box_cull_core
// Self-checking bench for the box culling core. A queue of load and test
// words feeds a clocked driver. A clocked monitor keeps its own copy of the
// 24 plane coefficients and works out the expected verdict of every test
// word with exact wide arithmetic. Four phases of sender idling and receiver
// stalling run in turn: a directed opening, then random camera scenes.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull_core;

    localparam int COORD_BITS = 32;

    localparam int FIELD_W      = fbc_pkg::FIELD_W;
    localparam int FRAC_BITS    = fbc_pkg::FRAC_BITS;
    localparam int PLANE_COUNT  = fbc_pkg::PLANE_COUNT;
    localparam int COLUMN_COUNT = fbc_pkg::COLUMN_COUNT;
    localparam int AXIS_COUNT   = fbc_pkg::AXIS_COUNT;
    localparam int COL_W        = fbc_pkg::COL_W;

    localparam logic [FIELD_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [FIELD_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] Q_ONE = 32'h0001_0000;

    // one input word, every field as it stands on the ports
    typedef struct packed {
        fbc_pkg::t_kind                       kind;
        logic [COL_W-1:0]                     column;
        logic [COLUMN_COUNT-1:0][FIELD_W-1:0] entry;
        logic [AXIS_COUNT-1:0][FIELD_W-1:0]   box_lo;
        logic [AXIS_COUNT-1:0][FIELD_W-1:0]   box_hi;
    } t_cull_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_visible;
    t_cull_word in_word     = '0;

    t_cull_word word_queue[$];
    logic       verdict_queue[$];
    longint     plane_coef[PLANE_COUNT][COLUMN_COUNT];
    logic       in_taken       = 1'b0;
    int         idle_pct       = 0;
    int         stall_pct      = 0;
    int         mismatch_count = 0;

    frustum_box_cull_core #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (in_word.kind),
        .i_column    (in_word.column),
        .i_entry_0   (in_word.entry[0]),
        .i_entry_1   (in_word.entry[1]),
        .i_entry_2   (in_word.entry[2]),
        .i_entry_3   (in_word.entry[3]),
        .i_box_min_x (in_word.box_lo[0]),
        .i_box_min_y (in_word.box_lo[1]),
        .i_box_min_z (in_word.box_lo[2]),
        .i_box_max_x (in_word.box_hi[0]),
        .i_box_max_y (in_word.box_hi[1]),
        .i_box_max_z (in_word.box_hi[2]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_visible   (o_visible)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // low COORD_BITS bits of a field, sign-extended
    function automatic longint to_coord(input logic [FIELD_W-1:0] raw);
        longint wide;
        wide = longint'(signed'(raw));
        return (wide <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
    endfunction

    // a load word writes one column of all six planes: row 3 +/- row r
    function automatic void store_column(input t_cull_word w);
        longint offs;
        offs = to_coord(w.entry[3]);
        for (int r = 0; r < AXIS_COUNT; r++) begin
            plane_coef[2 * r][w.column]     = offs + to_coord(w.entry[r]);
            plane_coef[2 * r + 1][w.column] = offs - to_coord(w.entry[r]);
        end
    endfunction

    // positive vertex against each plane; exact distance in 2^-32 units
    function automatic logic box_visible(input t_cull_word w);
        logic signed [71:0] plane_dist;
        logic signed [71:0] nrm;
        logic signed [71:0] pos;
        logic               culled;
        culled = 1'b0;
        for (int k = 0; k < PLANE_COUNT; k++) begin
            // all-zero normal never rejects
            if (plane_coef[k][0] != 0 || plane_coef[k][1] != 0 || plane_coef[k][2] != 0) begin
                plane_dist = plane_coef[k][3];
                plane_dist = plane_dist <<< FRAC_BITS;
                for (int a = 0; a < AXIS_COUNT; a++) begin
                    nrm  = plane_coef[k][a];
                    pos  = (plane_coef[k][a] >= 0) ? to_coord(w.box_hi[a])
                                                   : to_coord(w.box_lo[a]);
                    plane_dist = plane_dist + nrm * pos;
                end
                if (plane_dist < 0) begin
                    culled = 1'b1;
                end
            end
        end
        return !culled;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // every field random, so unused fields carry noise too
    function automatic t_cull_word random_word();
        t_cull_word w;
        w.kind   = fbc_pkg::t_kind'($urandom_range(1));
        w.column = COL_W'($urandom);
        for (int i = 0; i < COLUMN_COUNT; i++) begin
            w.entry[i] = $urandom;
        end
        for (int a = 0; a < AXIS_COUNT; a++) begin
            w.box_lo[a] = $urandom;
            w.box_hi[a] = $urandom;
        end
        return w;
    endfunction

    function automatic logic [FIELD_W-1:0] extreme_value();
        case ($urandom_range(4))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            default: return Q_ONE;
        endcase
    endfunction

    // mostly moderate Q16.16 values, some full range, some extremes
    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return $urandom;
            1: return extreme_value();
            default: return FIELD_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    task automatic queue_load(input int col, input logic [FIELD_W-1:0] e0,
                              input logic [FIELD_W-1:0] e1, input logic [FIELD_W-1:0] e2,
                              input logic [FIELD_W-1:0] e3);
        t_cull_word w;
        w          = random_word();
        w.kind     = fbc_pkg::KIND_LOAD;
        w.column   = COL_W'(col);
        w.entry[0] = e0;
        w.entry[1] = e1;
        w.entry[2] = e2;
        w.entry[3] = e3;
        word_queue.push_back(w);
    endtask

    task automatic queue_test(input logic [FIELD_W-1:0] lx, input logic [FIELD_W-1:0] ly,
                              input logic [FIELD_W-1:0] lz, input logic [FIELD_W-1:0] hx,
                              input logic [FIELD_W-1:0] hy, input logic [FIELD_W-1:0] hz);
        t_cull_word w;
        w           = random_word();
        w.kind      = fbc_pkg::KIND_TEST;
        w.box_lo[0] = lx;
        w.box_lo[1] = ly;
        w.box_lo[2] = lz;
        w.box_hi[0] = hx;
        w.box_hi[1] = hy;
        w.box_hi[2] = hz;
        word_queue.push_back(w);
    endtask

    // directed opening: empty planes, offsets only, extremes, a plain camera, an inverted box
    task automatic queue_directed(output int added);
        int start;
        start = word_queue.size();
        // nothing loaded: every normal zero
        queue_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        queue_test('0, '0, '0, '0, '0, '0);
        // offsets only, normals still zero
        queue_load(3, '1, '1, '1, Q_MIN);
        queue_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        // extreme coefficients
        queue_load(0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_load(1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_load(2, Q_MAX, Q_MIN, '0, Q_MIN);
        queue_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        queue_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        queue_test('0, '0, '0, '0, '0, '0);
        queue_load(3, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
        queue_test(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        queue_test(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        // plain perspective camera looking down -z
        queue_load(0, Q_ONE, '0, '0, '0);
        queue_load(1, '0, Q_ONE, '0, '0);
        queue_load(2, '0, '0, -Q_ONE, -Q_ONE);
        queue_load(3, '0, '0, -(Q_ONE >> 1), '0);
        queue_test(-Q_ONE, -Q_ONE, -6 * Q_ONE, Q_ONE, Q_ONE, -4 * Q_ONE);
        queue_test(-Q_ONE, -Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE, 6 * Q_ONE);
        queue_test(100 * Q_ONE, -Q_ONE, -6 * Q_ONE, 101 * Q_ONE, Q_ONE, -4 * Q_ONE);
        // inverted box, min above max
        queue_test(Q_ONE, Q_ONE, -4 * Q_ONE, -Q_ONE, -Q_ONE, -6 * Q_ONE);
        queue_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        added = word_queue.size() - start;
    endtask

    // one random scene: a matrix load (full or partial), then a run of boxes
    task automatic queue_scene(output int added);
        logic [FIELD_W-1:0] m [COLUMN_COUNT][COLUMN_COUNT];
        int start;
        int pick;
        int first;
        int n_cols;
        int n_tests;
        int r0;
        int ctr [AXIS_COUNT];
        int half;
        logic [FIELD_W-1:0] lo [AXIS_COUNT];
        logic [FIELD_W-1:0] hi [AXIS_COUNT];
        logic [FIELD_W-1:0] tmp;
        start  = word_queue.size();
        pick   = $urandom_range(9);
        first  = $urandom_range(3);
        n_cols = COLUMN_COUNT;
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            for (int r = 0; r < COLUMN_COUNT; r++) begin
                m[c][r] = (pick >= 8) ? pick_value() : '0;
            end
        end
        if (pick < 7) begin
            // perspective camera with jitter and a shift
            m[1][1] = FIELD_W'(32768 + $urandom_range(0, 163840));
            m[0][0] = m[1][1] + FIELD_W'($urandom_range(0, 32768));
            m[2][2] = FIELD_W'(-(65536 + int'($urandom_range(0, 8192))));
            m[2][3] = -Q_ONE;
            m[3][2] = FIELD_W'(-int'($urandom_range(6554, 131072)));
            m[3][0] = FIELD_W'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
            m[3][1] = FIELD_W'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                for (int r = 0; r < COLUMN_COUNT; r++) begin
                    if ($urandom_range(3) == 0) begin
                        m[c][r] = m[c][r] + FIELD_W'(int'($urandom_range(0, 16384)) - 8192);
                    end
                end
            end
        end else if (pick == 7) begin
            // one plane gets an all-zero normal
            r0 = $urandom_range(2);
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                for (int r = 0; r < COLUMN_COUNT; r++) begin
                    m[c][r] = pick_value();
                end
                if (c < AXIS_COUNT) begin
                    m[c][3] = m[c][r0];
                end
            end
        end else if (pick == 9) begin
            // partial reload
            n_cols = $urandom_range(1, 2);
        end
        for (int i = 0; i < n_cols; i++) begin
            queue_load((first + i) % COLUMN_COUNT, m[(first + i) % COLUMN_COUNT][0],
                       m[(first + i) % COLUMN_COUNT][1], m[(first + i) % COLUMN_COUNT][2],
                       m[(first + i) % COLUMN_COUNT][3]);
        end

        n_tests = $urandom_range(3, 12);
        for (int t = 0; t < n_tests; t++) begin
            pick   = $urandom_range(9);
            ctr[0] = int'($urandom_range(0, 16 * 65536)) - 8 * 65536;
            ctr[1] = int'($urandom_range(0, 16 * 65536)) - 8 * 65536;
            ctr[2] = 2 * 65536 - int'($urandom_range(0, 20 * 65536));
            for (int a = 0; a < AXIS_COUNT; a++) begin
                half  = $urandom_range(0, 3 * 65536);
                lo[a] = FIELD_W'(ctr[a] - half);
                hi[a] = FIELD_W'(ctr[a] + half);
                if (pick == 7) begin
                    tmp   = lo[a];
                    lo[a] = hi[a];
                    hi[a] = tmp;
                end else if (pick == 8) begin
                    lo[a] = pick_value();
                    hi[a] = pick_value();
                end else if (pick == 9) begin
                    lo[a] = extreme_value();
                    hi[a] = extreme_value();
                end
            end
            queue_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        end
        added = word_queue.size() - start;
    endtask

    // driver: new word on the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (!i_in_valid || in_taken) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_word    <= word_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: track accepted words, check every result word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                if (in_word.kind == fbc_pkg::KIND_LOAD) begin
                    store_column(in_word);
                end else begin
                    verdict_queue.push_back(box_visible(in_word));
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result word with no test pending");
                end else if (o_visible !== verdict_queue[0]) begin
                    report_mismatch($sformatf("visible got %b want %b",
                                              o_visible, verdict_queue[0]));
                    void'(verdict_queue.pop_front());
                end else begin
                    void'(verdict_queue.pop_front());
                end
            end
        end
    end

    // main sequence
    initial begin
        int queued;
        int added;
        int target [4];
        target = '{600, 450, 450, 450};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 86;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 86;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            queued = 0;
            if (phase == 0) begin
                queue_directed(queued);
            end
            while (queued < target[phase]) begin
                queue_scene(added);
                queued += added;
            end
            while (word_queue.size() != 0 || i_in_valid || verdict_queue.size() != 0) begin
                @(posedge i_clk);
            end
        end

        // catch stray result words after the last one
        repeat (30) @(posedge i_clk);
        if (verdict_queue.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", verdict_queue.size()));
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/fbc_pkg.sv
src/frustum_box_cull_core.sv
bench/tb_frustum_box_cull_core.sv
